// File: hw/rtl/nfp_pkg.sv
package nfp_pkg;

  // Mask bits that follow the base number in one chunk.
  localparam int unsigned SPAN = 16;

  typedef struct packed {
    logic        last;
    logic [15:0] blp;
    logic [15:0] pid;
  } chunk_t;

  typedef struct packed {
    logic        open;
    logic [15:0] base;
    logic [15:0] mask;
  } pack_state_t;

  // Chunks produced by one item, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    chunk_t     first;
    chunk_t     second;
  } emit_t;

endpackage

// File: hw/rtl/nfp_chunk_step.sv
module nfp_chunk_step (
  input  nfp_pkg::pack_state_t state,
  input  logic [15:0]          seq_num,
  input  logic                 is_last,
  output nfp_pkg::pack_state_t state_next,
  output nfp_pkg::emit_t       emit
);
  import nfp_pkg::*;

  logic [16:0] diff_wide;
  logic [15:0] diff;
  logic        above;
  logic        far;
  logic [3:0]  bit_pos;
  logic [15:0] base_upd;
  logic [15:0] mask_upd;
  chunk_t      closed_chunk;
  chunk_t      final_chunk;

  assign diff_wide = {1'b0, seq_num} - {1'b0, state.base};
  assign diff      = diff_wide[15:0];
  // No borrow and a nonzero difference means the number lies above the base.
  assign above     = !diff_wide[16] && (diff != 16'd0);
  assign far       = above && (diff > 16'(SPAN));
  assign bit_pos   = 4'(diff - 16'd1);

  always_comb begin
    base_upd = state.base;
    mask_upd = state.mask;
    if (!state.open) begin
      base_upd = seq_num;
      mask_upd = 16'd0;
    end else if (far) begin
      base_upd = seq_num;
      mask_upd = 16'd0;
    end else if (above) begin
      mask_upd = state.mask | (16'd1 << bit_pos);
    end
  end

  assign closed_chunk = '{last: 1'b0, blp: state.mask, pid: state.base};
  assign final_chunk  = '{last: 1'b1, blp: mask_upd, pid: base_upd};

  always_comb begin
    emit.second = final_chunk;
    if (state.open && far) begin
      emit.first = closed_chunk;
      emit.count = is_last ? 2'd2 : 2'd1;
    end else begin
      emit.first = final_chunk;
      emit.count = is_last ? 2'd1 : 2'd0;
    end
  end

  always_comb begin
    if (is_last) begin
      state_next = '{open: 1'b0, base: 16'd0, mask: 16'd0};
    end else begin
      state_next = '{open: 1'b1, base: base_upd, mask: mask_upd};
    end
  end

endmodule

// File: hw/rtl/nfp_out_fifo.sv
module nfp_out_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  nfp_pkg::emit_t                emit,
  input  logic                          pop,
  output logic                          out_valid,
  output nfp_pkg::chunk_t               out_chunk,
  output logic [$clog2(DEPTH+1)-1:0]    count
);
  import nfp_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  chunk_t        mem [DEPTH];
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] wr_ptr_1;
  logic [PW-1:0] wr_ptr_2;
  logic [PW-1:0] rd_ptr_next;
  logic [1:0]    n_push;
  logic          do_pop;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  assign n_push      = push ? emit.count : 2'd0;
  assign do_pop      = pop && (count != '0);
  assign wr_ptr_1    = wrap_inc(wr_ptr);
  assign wr_ptr_2    = wrap_inc(wr_ptr_1);
  assign rd_ptr_next = wrap_inc(rd_ptr);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= emit.first;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr_1] <= emit.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      unique case (n_push)
        2'd1:    wr_ptr <= wr_ptr_1;
        2'd2:    wr_ptr <= wr_ptr_2;
        default: wr_ptr <= wr_ptr;
      endcase
      if (do_pop) begin
        rd_ptr <= rd_ptr_next;
      end
      count <= count + CW'(n_push) - CW'(do_pop);
    end
  end

  assign out_valid = (count != '0);
  assign out_chunk = mem[rd_ptr];

endmodule

// File: hw/rtl/nack_fci_packer_core.sv
// Generic NACK chunk packer: lost sequence numbers in, PID/BLP chunks out.
// A chunk enters the queue with the beat that closes it and reaches the master side behind older chunks.
// One input beat per cycle while the queue has room; an item that closes two chunks queues both at once.
// The input side is held off only by the chunk queue, which must keep room for two chunks.
// Reset (rst, synchronous, active high) closes any open chunk and empties the queue.
module nack_fci_packer_core #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Slave side: lost sequence numbers.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] seq_num
  input  logic        s_tlast,   // is_last
  // Master side: NACK chunks.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] chunk_pid, [31:16] chunk_blp
  output logic        m_tlast    // chunk_last
);
  import nfp_pkg::*;

  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  pack_state_t state;
  pack_state_t state_next;
  emit_t       emit;
  chunk_t      out_chunk;
  logic        s_beat;
  logic [CW-1:0] fill;

  // The queue admits a beat only while it has room for the two chunks that one
  // beat can produce. The check looks at the registered fill level alone, so
  // no combinational path runs from m_tready to s_tready.
  assign s_tready = (fill <= CW'(FIFO_DEPTH - 2));
  assign s_beat   = s_tvalid && s_tready;

  // The open chunk: base number, mask of numbers that follow it, and a flag
  // that a chunk is being collected. Every accepted beat updates it in the
  // same cycle, so consecutive beats need no bypass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{open: 1'b0, base: 16'd0, mask: 16'd0};
    end else if (s_beat) begin
      state <= state_next;
    end
  end

  nfp_chunk_step u_step (
    .state      (state),
    .seq_num    (s_tdata),
    .is_last    (s_tlast),
    .state_next (state_next),
    .emit       (emit)
  );

  // Chunks wait here until the master side takes them, first chunk first.
  nfp_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s_beat),
    .emit      (emit),
    .pop       (m_tready),
    .out_valid (m_tvalid),
    .out_chunk (out_chunk),
    .count     (fill)
  );

  assign m_tdata = {out_chunk.blp, out_chunk.pid};
  assign m_tlast = out_chunk.last;

  // The queue never holds more chunks than it has entries.
  assert property (@(posedge clk) disable iff (rst) fill <= CW'(FIFO_DEPTH))
    else $error("chunk queue overflow");

  // A beat that closes a chunk makes one visible on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
      (s_beat && emit.count != 2'd0) |=> m_tvalid)
    else $error("closed chunk not presented");

  // The last beat of a report leaves no chunk open.
  assert property (@(posedge clk) disable iff (rst) (s_beat && s_tlast) |=> !state.open)
    else $error("chunk still open after last beat");

  // When no beat is accepted, the packer state holds, whether or not a chunk is open.
  assert property (@(posedge clk) disable iff (rst) !s_beat |=> $stable(state))
    else $error("open chunk changed without a beat");

endmodule

// File: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nfp_pkg::*;

  // Receiver behavior for one stretch of cycles.
  typedef enum logic [1:0] {
    RX_ALWAYS_READY,
    RX_MOSTLY_READY,
    RX_MOSTLY_STALLED,
    RX_FIXED_PATTERN
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;

  // Shadow copy of the packer state, advanced on every accepted input beat.
  logic        shadow_open = 1'b0;
  logic [15:0] shadow_base = 16'd0;
  logic [15:0] shadow_mask = 16'd0;

  // Chunks the packer still owes us, oldest first.
  chunk_t      owed_chunks[$];
  int          error_count = 0;

  // Remaining beats in the current sender burst; zero forces a gap first.
  int          burst_left = 0;

  rx_mode_t    rx_mode = RX_ALWAYS_READY;
  int          rx_stretch_left = 0;

  always #5 clk = ~clk;

  nack_fci_packer_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Queue one expected chunk.
  task automatic owe_chunk(input logic [15:0] pid, input logic [15:0] blp, input logic last);
    chunk_t c;
    c.pid  = pid;
    c.blp  = blp;
    c.last = last;
    owed_chunks.push_back(c);
  endtask

  // Advance the shadow state by one lost sequence number. A number far above
  // the base closes the open chunk and starts a new one; a number at or below
  // the base is ignored. The last beat of a report always flushes a chunk.
  task automatic pack_lost_seq(input logic [15:0] sn, input logic last);
    int delta;
    delta = int'(sn) - int'(shadow_base);
    if (!shadow_open) begin
      shadow_open = 1'b1;
      shadow_base = sn;
      shadow_mask = 16'd0;
    end else if (delta > int'(SPAN)) begin
      owe_chunk(shadow_base, shadow_mask, 1'b0);
      shadow_base = sn;
      shadow_mask = 16'd0;
    end else if (delta >= 1) begin
      shadow_mask[delta-1] = 1'b1;
    end
    if (last) begin
      owe_chunk(shadow_base, shadow_mask, 1'b1);
      shadow_open = 1'b0;
      shadow_base = 16'd0;
      shadow_mask = 16'd0;
    end
  endtask

  // Everything is sampled at the rising edge, before the design's updates land.
  // The prediction for an input beat is made before the output beat of the same
  // edge is checked, so the queue is never short by a chunk closed on this edge.
  always @(posedge clk) begin : chunk_checker
    chunk_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pack_lost_seq(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        if (owed_chunks.size() == 0) begin
          $error("unexpected chunk: pid 0x%04h blp 0x%04h last %0b",
                 m_tdata[15:0], m_tdata[31:16], m_tlast);
          error_count++;
        end else begin
          want = owed_chunks.pop_front();
          if (m_tdata[15:0] !== want.pid) begin
            $error("chunk_pid mismatch: expected 0x%04h, actual 0x%04h",
                   want.pid, m_tdata[15:0]);
            error_count++;
          end
          if (m_tdata[31:16] !== want.blp) begin
            $error("chunk_blp mismatch: expected 0x%04h, actual 0x%04h",
                   want.blp, m_tdata[31:16]);
            error_count++;
          end
          if (m_tlast !== want.last) begin
            $error("chunk_last mismatch: expected %0b, actual %0b", want.last, m_tlast);
            error_count++;
          end
        end
      end
    end
  end

  // The receiver picks a behavior for a stretch of cycles, then picks again.
  // Always-ready stretches give runs with no back-pressure at all.
  always @(negedge clk) begin
    if (rx_stretch_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_stretch_left = $urandom_range(20, 200);
    end
    rx_stretch_left--;
    case (rx_mode)
      RX_ALWAYS_READY:   m_tready <= 1'b1;
      RX_MOSTLY_READY:   m_tready <= ($urandom_range(0, 3) != 0);
      RX_MOSTLY_STALLED: m_tready <= ($urandom_range(0, 3) == 0);
      default:           m_tready <= ((rx_stretch_left % 7) < 3);
    endcase
  end

  // Present one beat at the falling edge and hold it until it is taken.
  // Between bursts the valid line drops for a random gap with junk on the data.
  // Returns at the falling edge after the accepting rising edge, so the caller
  // either drives the next beat or drops valid in that same step.
  task automatic send_beat(input logic [15:0] sn, input logic last);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 16'($urandom);
      s_tlast  <= 1'($urandom);
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= sn;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Hand-picked reports: extremes of the number range, both mask ends,
  // the skip cases, a last beat that closes two chunks, and a repeated bit.
  task automatic test_directed();
    send_beat(16'd0, 1'b0);          // opens a chunk at base 0
    send_beat(16'd1, 1'b0);          // lowest mask bit
    send_beat(16'd16, 1'b0);         // highest mask bit
    send_beat(16'd16, 1'b0);         // same bit again, no change
    send_beat(16'd0, 1'b0);          // equal to base, skipped
    send_beat(16'd17, 1'b0);         // one past the span closes the chunk
    send_beat(16'd5, 1'b1);          // skipped, but still flushes the chunk
    send_beat(16'hFFFF, 1'b1);       // one-beat report
    send_beat(16'hFFFF, 1'b0);       // base at the top of the range
    send_beat(16'd0, 1'b0);          // far below base, skipped
    send_beat(16'hFFFE, 1'b0);       // just below base, skipped
    send_beat(16'hFFFF, 1'b1);       // equal to base on the last beat
    send_beat(16'd100, 1'b0);
    send_beat(16'd200, 1'b1);        // closes one chunk and ends the next
    send_beat(16'hFFEF, 1'b0);
    send_beat(16'hFFFF, 1'b0);       // top mask bit near the range end
    send_beat(16'hFFF0, 1'b1);       // bottom mask bit on the last beat
    send_beat(16'd0, 1'b0);
    send_beat(16'hFFFF, 1'b1);       // largest possible jump, two chunks
    send_beat(16'h5555, 1'b0);
    send_beat(16'hAAAA, 1'b1);
  endtask

  // Well-formed reports: mostly ascending numbers with small steps so masks
  // fill up, some steps past the span, and a few repeats and backward steps.
  task automatic test_ascending_reports(input int n_beats);
    int sent;
    int len;
    int sn;
    int pick;
    int k;
    sent = 0;
    while (sent < n_beats) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      case ($urandom_range(0, 3))
        0:       sn = $urandom_range(65500, 65535);
        1:       sn = $urandom_range(0, 40);
        default: sn = $urandom_range(0, 65535);
      endcase
      for (k = 0; k < len; k++) begin
        send_beat(16'(sn), k == len - 1);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          sn = sn + $urandom_range(1, 4);
        end else if (pick < 80) begin
          sn = sn + $urandom_range(5, 16);
        end else if (pick < 92) begin
          sn = sn + $urandom_range(17, 40);
        end else if (pick >= 97) begin
          sn = sn - $urandom_range(1, 20);
        end
        // A repeat keeps sn as it is. Running off the top wraps to small
        // numbers, which the packer treats as far below the base.
        sn = sn & 16'hFFFF;
      end
      sent += len;
    end
  endtask

  // Arbitrary numbers with an occasional last flag.
  task automatic test_noise(input int n_beats);
    int k;
    for (k = 0; k < n_beats; k++) begin
      send_beat(16'($urandom), $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_ascending_reports(1200);
    test_noise(330);
    // Flush whatever chunk the noise left open.
    send_beat(16'($urandom), 1'b1);
    s_tvalid <= 1'b0;
    while (owed_chunks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Backstop against a hung handshake.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
